// ===== rtl/crcic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crcic_pkg;

	localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES        = 32'hFFFF_FFFF;
	localparam logic [31:0] START_POS_RESET = 32'h0000_0010;
	localparam logic [31:0] END_POS_RESET   = 32'h0000_0014;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_START_POS = 1'b0,
		CFG_END_POS   = 1'b1
	} crcic_cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} crcic_in_t;

	typedef struct packed {
		logic [31:0] crc_value;
		logic        crc_match;
	} crcic_out_t;

	// skip window settings
	typedef struct packed {
		logic [31:0] start_pos;
		logic [31:0] end_pos;
	} crcic_win_t;

	// reflected CRC-32, one byte, bitwise
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int n = 0; n < 8; n++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crcic_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcic_engine
	import crcic_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire crcic_win_t win,
	input  wire logic       step,
	input  wire crcic_in_t  item,
	output crcic_out_t      result
);

	logic [31:0] crc_q;
	logic [31:0] pos_q;
	logic [31:0] stored_q;

	logic [31:0] crc_base;
	logic [31:0] pos;
	logic [31:0] stored_base;
	logic [31:0] stored_nxt;
	logic [31:0] k;
	logic        in_win;
	logic [7:0]  feed;
	logic [31:0] crc_nxt;
	logic [31:0] pos_nxt;
	logic [31:0] fin;

	always_comb begin
		crc_base    = item.first_byte ? CRC_ONES : crc_q;
		pos         = item.first_byte ? 32'h0 : pos_q;
		stored_base = item.first_byte ? 32'h0 : stored_q;

		in_win = (pos >= win.start_pos) && (pos < win.end_pos);
		k      = pos - win.start_pos;
		feed   = in_win ? 8'h00 : item.data_byte;

		// little-endian capture of the first four window bytes
		stored_nxt = stored_base;
		if (in_win && (k[31:2] == 30'h0)) begin
			case (k[1:0])
				2'd0:    stored_nxt[7:0]   = item.data_byte;
				2'd1:    stored_nxt[15:8]  = item.data_byte;
				2'd2:    stored_nxt[23:16] = item.data_byte;
				2'd3:    stored_nxt[31:24] = item.data_byte;
				default: stored_nxt        = stored_base;
			endcase
		end

		crc_nxt = crc32_byte(crc_base, feed);
		pos_nxt = (pos == CRC_ONES) ? pos : pos + 32'd1;
		fin     = crc_nxt ^ CRC_ONES;

		result.crc_value = fin;
		result.crc_match = (fin == stored_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_ONES;
			pos_q    <= 32'h0;
			stored_q <= 32'h0;
		end else if (step) begin
			crc_q    <= crc_nxt;
			pos_q    <= pos_nxt;
			stored_q <= stored_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crc32_image_check_with_skip_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------------
// byte in  | byte_valid   | byte_stall   | byte_data   (data, first, last flags)
// result   | result_valid | result_stall | result_data (crc_value, crc_match)
// config   | cfg_we       | -            | cfg_index, cfg_data
//
// One byte per cycle unless a last byte stalls: a beat lands in the input
// register, and the byte-wide CRC update and window logic then commit it to
// the state. The edge that commits a last byte also loads its result into
// the output register.
// Reset: CRC all ones, position and stored checksum zero, window 0x10 to 0x14 (end exclusive).
// byte_stall rises only when a last byte waits behind an unaccepted result.

module crc32_image_check_with_skip_unit
	import crcic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire crcic_in_t   byte_data,

	output logic             result_valid,
	input  wire logic        result_stall,
	output crcic_out_t       result_data,

	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	crcic_win_t win_q;

	logic       valid_s1;
	crcic_in_t  item_s1;
	logic       step;
	logic       out_free;
	crcic_out_t eng_result;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.start_pos <= START_POS_RESET;
			win_q.end_pos   <= END_POS_RESET;
		end else if (cfg_we) begin
			case (crcic_cfg_idx_t'(cfg_index))
				CFG_START_POS: win_q.start_pos <= cfg_data;
				CFG_END_POS:   win_q.end_pos   <= cfg_data;
				default:       win_q           <= win_q;
			endcase
		end
	end

	// output slot is free when empty or being drained this cycle
	assign out_free = !result_valid || !result_stall;

	// non-last bytes never need the output slot
	assign step       = valid_s1 && (!item_s1.last_byte || out_free);
	assign byte_stall = valid_s1 && !step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	crcic_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.win    (win_q),
		.step   (step),
		.item   (item_s1),
		.result (eng_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			result_data <= eng_result;
		end
	end

	// a blocked last byte stays in the input register
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_byte && result_valid && result_stall) |=> valid_s1)
		else $error("blocked last byte dropped");

	// stall only comes from a full, stalled output slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without output backpressure");

	// a committed last byte always shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=> result_valid)
		else $error("result missing after last byte");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// CRC-32 image check testbench.
// Image bytes go in as beats on the byte channel. Each accepted beat is
// folded into a local copy of the CRC, position and stored-checksum state.
// A last byte pushes the expected result onto a queue. The result monitor
// pops that queue on every accepted result and compares it field by field.
// Both sides idle at random, with some stretches where neither idles.
// The skip window is rewritten only once the unit has drained.

module tb_top;
	import crcic_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	crcic_in_t   byte_data = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	crcic_out_t  result_data;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = CFG_START_POS;
	logic [31:0] cfg_data = '0;

	crc32_image_check_with_skip_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Local copy of the unit's state
	// ---------------------------------------------------------------
	logic [31:0] win_start = START_POS_RESET;
	logic [31:0] win_end   = END_POS_RESET;
	logic [31:0] crc_acc   = CRC_ONES;
	logic [31:0] byte_pos  = '0;
	logic [31:0] cksum_store = '0;

	crcic_out_t  pending_crc_q[$];   // results still owed by the unit
	crcic_out_t  crc_want;
	int          fails = 0;
	int          beats_sent = 0;
	int          idle_mode = 0;      // 0: no idling, 1: short gaps, 2: short and long
	int          stall_left = 0;

	logic [7:0]  img [64];           // image buffer for the well-formed images

	// Reflected CRC-32, one byte: shift out LSB first, fold in the polynomial on a one.
	function automatic logic [31:0] crc_fold_byte(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'd0, d};
		repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	function automatic bit in_window(input logic [31:0] p);
		return (p >= win_start) && (p < win_end);
	endfunction

	// Advance the local state by one accepted beat; queue a result on a last byte.
	function automatic void image_crc_track(input crcic_in_t b);
		logic [31:0] k;
		logic [7:0]  feed;
		crcic_out_t  res;
		if (b.first_byte) begin
			crc_acc = CRC_ONES;
			byte_pos = '0;
			cksum_store = '0;
		end
		feed = b.data_byte;
		if (in_window(byte_pos)) begin
			// skipped bytes count as zero; the first four are the stored checksum,
			// little-endian
			feed = 8'h00;
			k = byte_pos - win_start;
			if (k < 4) begin
				cksum_store[k[1:0]*8 +: 8] = b.data_byte;
			end
		end
		crc_acc = crc_fold_byte(crc_acc, feed);
		// position saturates at all ones
		if (byte_pos != CRC_ONES) begin
			byte_pos = byte_pos + 1;
		end
		if (b.last_byte) begin
			res.crc_value = crc_acc ^ CRC_ONES;
			res.crc_match = (res.crc_value == cksum_store);
			pending_crc_q.push_back(res);
		end
	endfunction

	// Random bytes in img[0..len-1]. When it is asked to, the first four window bytes
	// are set to the image's CRC, so that the stored checksum matches.
	function automatic void fill_image(input int len, input bit consistent);
		logic [31:0] c;
		c = CRC_ONES;
		for (int i = 0; i < len; i++) begin
			img[i] = 8'($urandom);
		end
		if (consistent) begin
			for (int p = 0; p < len; p++) begin
				c = crc_fold_byte(c, in_window(p) ? 8'h00 : img[p]);
			end
			c = c ^ CRC_ONES;
			for (int k = 0; k < 4; k++) begin
				img[win_start + k] = c[k*8 +: 8];
			end
		end
	endfunction

	// Gap length: none in mode 0; else mostly none, some short, and a few long in mode 2.
	function automatic int idle_gap();
		int r;
		if (idle_mode == 0) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92 || idle_mode == 1) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 30);
		end
	endfunction

	// ---------------------------------------------------------------
	// Byte channel driver. It is entered and left on a falling edge. Valid stays
	// high from one beat to the next unless a gap is drawn.
	// ---------------------------------------------------------------
	task automatic send_beat(input logic [7:0] d, input logic f, input logic l);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_data.data_byte = d;
		byte_data.first_byte = f;
		byte_data.last_byte = l;
		byte_valid = 1'b1;
		do @(posedge clk); while (byte_stall);
		image_crc_track(byte_data);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_image(input int len);
		for (int i = 0; i < len; i++) begin
			send_beat(img[i], i == 0, i == len - 1);
		end
	endtask

	// Drain: every owed result accepted, then a wait for the pipeline
	// (input register, commit, output register) to empty after a trailing
	// byte that owes no result.
	task automatic settle();
		byte_valid = 1'b0;
		while (pending_crc_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic cfg_write(input crcic_cfg_idx_t idx, input logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		if (idx == CFG_START_POS) begin
			win_start = v;
		end else begin
			win_end = v;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_window(input logic [31:0] s, input logic [31:0] e);
		settle();
		cfg_write(CFG_START_POS, s);
		cfg_write(CFG_END_POS, e);
	endtask

	// ---------------------------------------------------------------
	// Result side: random stall, and a check of each accepted result
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			stall_left = idle_gap();
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (pending_crc_q.size() == 0) begin
				$error("unexpected result: crc_value %h crc_match %b",
					result_data.crc_value, result_data.crc_match);
				fails++;
			end else begin
				crc_want = pending_crc_q.pop_front();
				if (result_data.crc_value !== crc_want.crc_value) begin
					$error("crc_value: expected %h, got %h",
						crc_want.crc_value, result_data.crc_value);
					fails++;
				end
				if (result_data.crc_match !== crc_want.crc_match) begin
					$error("crc_match: expected %b, got %b",
						crc_want.crc_match, result_data.crc_match);
					fails++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------

	// No first flag directly after reset: the reset state is the start of the image.
	task automatic test_missing_first();
		for (int i = 0; i < 3; i++) begin
			send_beat(8'($urandom), 1'b0, i == 2);
		end
	endtask

	// Bytes after a last byte with no first flag carry on from the kept state.
	task automatic test_continue_after_last();
		send_beat(8'($urandom), 1'b0, 1'b0);
		send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	// First and last on one beat, at both extremes of the data byte.
	task automatic test_one_byte_images();
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
	endtask

	// Four-byte window at position 0 that holds the image's own CRC.
	task automatic test_exact_window();
		set_window(32'd0, 32'd4);
		fill_image(5, 1'b1);
		send_image(5);
	endtask

	// The window is wider than the checksum: bytes 4 and 5 are zeroed but not captured.
	task automatic test_wide_window();
		set_window(32'd0, 32'd6);
		fill_image(6, 1'b1);
		send_image(6);
	endtask

	// Window end equal to its start: nothing is skipped, the stored checksum stays zero.
	task automatic test_empty_window();
		set_window(32'd3, 32'd3);
		fill_image(3, 1'b0);
		send_image(3);
	endtask

	// The register extremes: every byte skipped, then an inverted window. Saturation
	// of the position would take 2^32 beats, so it is not reached.
	task automatic test_window_extremes();
		set_window(32'd0, CRC_ONES);
		fill_image(2, 1'b0);
		send_image(2);
		set_window(CRC_ONES, 32'd0);
		fill_image(1, 1'b0);
		send_image(1);
	endtask

	// ---------------------------------------------------------------
	// Random phases: a new window and idle mode each round. Most images are
	// well-formed, some of them carry their own CRC. The rest are loose beats
	// with stray flags.
	// ---------------------------------------------------------------
	task automatic test_random_images();
		int          round;
		int          round_beats;
		int          len;
		int          hi;
		bit          consistent;
		logic [31:0] s;
		logic [31:0] e;
		round = 0;
		while (beats_sent < 810) begin
			case (round % 8)
				0: begin s = START_POS_RESET; e = END_POS_RESET; end
				1: begin s = $urandom_range(0, 12); e = s + 4; end
				2: begin s = $urandom_range(0, 10); e = s + $urandom_range(5, 12); end
				3: begin s = $urandom_range(0, 16); e = s + $urandom_range(0, 3); end
				4: begin s = $urandom_range(0, 20); e = $urandom_range(0, s); end
				5: begin s = $urandom; e = $urandom; end
				6: begin s = 32'd0; e = CRC_ONES; end
				default: begin s = CRC_ONES; e = $urandom; end
			endcase
			set_window(s, e);
			idle_mode = round % 3;
			round_beats = 0;
			while (round_beats < 70) begin
				if ($urandom_range(0, 99) < 70) begin
					consistent = (win_end > win_start) && (win_end - win_start >= 4) &&
						(win_start <= 40) && ($urandom_range(0, 1) == 1);
					if (consistent) begin
						hi = win_start + 14;
						if (hi > 63) begin
							hi = 63;
						end
						len = $urandom_range(win_start + 4, hi);
					end else begin
						len = $urandom_range(1, 32);
					end
					fill_image(len, consistent);
					send_image(len);
				end else begin
					len = $urandom_range(1, 20);
					for (int i = 0; i < len; i++) begin
						send_beat(8'($urandom), $urandom_range(0, 9) == 0,
							(i == len - 1) ? ($urandom_range(0, 1) == 1)
								: ($urandom_range(0, 7) == 0));
					end
				end
				round_beats += len;
			end
			round++;
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_mode = 2;
		test_missing_first();
		test_continue_after_last();
		test_one_byte_images();
		test_exact_window();
		test_wide_window();
		test_empty_window();
		test_window_extremes();
		test_random_images();

		byte_valid = 1'b0;
		while (pending_crc_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fails == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus
	initial begin
		#20_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/crcic_pkg.sv
rtl/crcic_engine.sv
rtl/crc32_image_check_with_skip_unit.sv
test/tb_top.sv
